@@ hw/rtl/rmq_pkg.sv @@
// Package: payload types, formats and branch codes for the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ELEM_W    = 16;
    localparam int SUM_W     = ELEM_W + 1;          // pair sum or difference
    localparam int ARG_W     = ELEM_W + 3;          // signed root argument
    localparam int RAD_W     = 32;                  // radicand arg << FRAC_BITS
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DEN_W     = ROOT_W + 1;          // 2 * root
    localparam int NUM_W     = SUM_W + FRAC_BITS;   // (mag << FRAC_BITS) + root
    localparam int QUO_W     = NUM_W - 8;           // 2 * root >= 256 when valid
    localparam int CMP_W     = DEN_W + QUO_W;

    localparam logic [1:0] CASE_W = 2'd0;
    localparam logic [1:0] CASE_X = 2'd1;
    localparam logic [1:0] CASE_Y = 2'd2;
    localparam logic [1:0] CASE_Z = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m13;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
        logic signed [ELEM_W-1:0] m23;
        logic signed [ELEM_W-1:0] m31;
        logic signed [ELEM_W-1:0] m32;
        logic signed [ELEM_W-1:0] m33;
    } matrix_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] q_x;
        logic signed [ELEM_W-1:0] q_y;
        logic signed [ELEM_W-1:0] q_z;
        logic signed [ELEM_W-1:0] q_w;
        logic [1:0]               case_taken;
        logic                     bad_input;
    } quat_t;

endpackage

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Top level: pipelined rotation matrix to quaternion conversion.
//
//  channel  | valid         | stall          | payload
//  ---------+---------------+----------------+-----------------
//  matrix   | matrix_valid  | matrix_stall   | matrix (matrix_t)
//  result   | quat_valid    | quat_stall     | quat   (quat_t)
//
// One transaction per cycle while the output is not stalled; the path runs through the input register,
// branch-select stage, 16 square-root stages (one root bit each), a scaling stage,
// 23 divide stages (one quotient bit each, three dividers side by side) and the output register.
// Reset clears only the valid bits. A stall of a valid result at the output freezes every stage
// and raises matrix_stall in the same cycle.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             matrix_valid,
    output logic             matrix_stall,
    input  rmq_pkg::matrix_t matrix,
    output logic             quat_valid,
    input  logic             quat_stall,
    output rmq_pkg::quat_t   quat
);
    import rmq_pkg::*;

    localparam int SQ_N  = ROOT_W;
    localparam int DIV_N = QUO_W;

    typedef struct packed {
        logic [RAD_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic [1:0]                sel;
        logic                      bad;
        logic [2:0]                neg;
        logic [2:0][SUM_W-1:0]     mag;
    } sq_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]     rem;
        logic [2:0][QUO_W-1:0]     quo;
        logic [DEN_W-1:0]          den;
        logic [ROOT_W-1:0]         half;
        logic [1:0]                sel;
        logic                      bad;
        logic [2:0]                neg;
    } dv_t;

    logic    adv;
    logic    in_valid_reg;
    matrix_t in_reg;

    logic [SQ_N:0]  sq_valid_reg;
    sq_t            sq_reg [SQ_N+1];
    logic [DIV_N:0] dv_valid_reg;
    dv_t            dv_reg [DIV_N+1];

    logic  out_valid_reg;
    quat_t out_reg;
    quat_t out_next;

    assign adv          = !out_valid_reg || !quat_stall;
    assign matrix_stall = !adv;
    assign quat_valid   = out_valid_reg;
    assign quat         = out_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= '0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= matrix_valid;
            sq_valid_reg  <= {sq_valid_reg[SQ_N-1:0], in_valid_reg};
            dv_valid_reg  <= {dv_valid_reg[DIV_N-1:0], sq_valid_reg[SQ_N]};
            out_valid_reg <= dv_valid_reg[DIV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= matrix;
        end
    end

    // branch choice, root argument and off-diagonal pairs
    logic signed [ARG_W-1:0] trace, arg;
    logic signed [ARG_W-1:0] e11, e22, e33, one_c;
    logic signed [SUM_W-1:0] d_23m32, d_31m13, d_12m21, s_12p21, s_13p31, s_32p23;
    logic signed [SUM_W-1:0] d_sel [3];
    sq_t                     sq_next;

    always_comb
    begin
        e11   = ARG_W'(in_reg.m11);
        e22   = ARG_W'(in_reg.m22);
        e33   = ARG_W'(in_reg.m33);
        one_c = ARG_W'(1) <<< FRAC_BITS;
        trace = e11 + e22 + e33;
        d_23m32 = SUM_W'(in_reg.m23) - SUM_W'(in_reg.m32);
        d_31m13 = SUM_W'(in_reg.m31) - SUM_W'(in_reg.m13);
        d_12m21 = SUM_W'(in_reg.m12) - SUM_W'(in_reg.m21);
        s_12p21 = SUM_W'(in_reg.m12) + SUM_W'(in_reg.m21);
        s_13p31 = SUM_W'(in_reg.m13) + SUM_W'(in_reg.m31);
        s_32p23 = SUM_W'(in_reg.m32) + SUM_W'(in_reg.m23);
        sq_next = '0;
        if (trace > 0)
        begin
            sq_next.sel = CASE_W;
            arg = trace + one_c;
            d_sel[0] = d_23m32;
            d_sel[1] = d_31m13;
            d_sel[2] = d_12m21;
        end
        else if (e11 >= e22 && e11 >= e33)
        begin
            sq_next.sel = CASE_X;
            arg = one_c + e11 - e22 - e33;
            d_sel[0] = s_12p21;
            d_sel[1] = s_13p31;
            d_sel[2] = d_23m32;
        end
        else if (e22 > e33)
        begin
            sq_next.sel = CASE_Y;
            arg = one_c + e22 - e11 - e33;
            d_sel[0] = s_12p21;
            d_sel[1] = s_32p23;
            d_sel[2] = d_31m13;
        end
        else
        begin
            sq_next.sel = CASE_Z;
            arg = one_c + e33 - e11 - e22;
            d_sel[0] = s_13p31;
            d_sel[1] = s_32p23;
            d_sel[2] = d_12m21;
        end
        sq_next.bad = (arg <= 0);
        if (!sq_next.bad)
        begin
            sq_next.rem = RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS;
        end
        for (int i = 0; i < 3; i++)
        begin
            sq_next.neg[i] = d_sel[i][SUM_W-1];
            sq_next.mag[i] = d_sel[i][SUM_W-1] ? SUM_W'(-d_sel[i]) : SUM_W'(d_sel[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_next;
        end
    end

    // square root, one root bit per stage, most significant first
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        localparam int K = SQ_N - 1 - j;
        logic [RAD_W+1:0] trial;
        logic [RAD_W+1:0] rem_ext;
        sq_t              stage_next;

        always_comb
        begin
            trial   = ((RAD_W+2)'(sq_reg[j].root) << (K + 1)) + ((RAD_W+2)'(1) << (2 * K));
            rem_ext = (RAD_W+2)'(sq_reg[j].rem);
            stage_next = sq_reg[j];
            if (rem_ext >= trial)
            begin
                stage_next.rem  = RAD_W'(rem_ext - trial);
                stage_next.root = sq_reg[j].root | (ROOT_W'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[j+1] <= stage_next;
            end
        end
    end

    // scale: numerators (mag << FRAC_BITS) + root, divisor 2 * root
    dv_t dv_next;

    always_comb
    begin
        dv_next      = '0;
        dv_next.den  = {sq_reg[SQ_N].root, 1'b0};
        dv_next.half = ROOT_W'(((ROOT_W+1)'(sq_reg[SQ_N].root) + 1'b1) >> 1);
        dv_next.sel  = sq_reg[SQ_N].sel;
        dv_next.bad  = sq_reg[SQ_N].bad;
        dv_next.neg  = sq_reg[SQ_N].neg;
        for (int i = 0; i < 3; i++)
        begin
            dv_next.rem[i] = (NUM_W'(sq_reg[SQ_N].mag[i]) << FRAC_BITS)
                           + NUM_W'(sq_reg[SQ_N].root);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_next;
        end
    end

    // restoring division, one quotient bit per stage for all three pairs
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        localparam int I = DIV_N - 1 - j;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] rem_ext [3];
        dv_t              stage_next;

        always_comb
        begin
            shifted    = CMP_W'(dv_reg[j].den) << I;
            stage_next = dv_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                rem_ext[i] = CMP_W'(dv_reg[j].rem[i]);
                if (rem_ext[i] >= shifted)
                begin
                    stage_next.rem[i]    = NUM_W'(rem_ext[i] - shifted);
                    stage_next.quo[i][I] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j+1] <= stage_next;
            end
        end
    end

    // sign, saturate and place the components
    logic signed [ELEM_W-1:0] comp [3];
    logic signed [ELEM_W-1:0] slot [4];
    logic [1:0]               root_pos;
    dv_t                      last;

    always_comb
    begin
        last = dv_reg[DIV_N];
        for (int i = 0; i < 3; i++)
        begin
            if (last.neg[i])
            begin
                if (last.quo[i] > QUO_W'(32768))
                    comp[i] = -16'sd32768;
                else
                    comp[i] = ELEM_W'(-$signed({1'b0, last.quo[i]}));
            end
            else
            begin
                if (last.quo[i] > QUO_W'(32767))
                    comp[i] = 16'sd32767;
                else
                    comp[i] = ELEM_W'(last.quo[i]);
            end
        end
        unique case (last.sel)
            CASE_W:  root_pos = 2'd3;
            CASE_X:  root_pos = 2'd0;
            CASE_Y:  root_pos = 2'd1;
            default: root_pos = 2'd2;
        endcase
        for (int p = 0; p < 4; p++)
        begin
            if (last.bad)
                slot[p] = '0;
            else if (2'(p) == root_pos)
                slot[p] = ELEM_W'(last.half);
            else if (2'(p) < root_pos)
                slot[p] = comp[p];
            else
                slot[p] = comp[p-1];
        end
        out_next.q_x        = slot[0];
        out_next.q_y        = slot[1];
        out_next.q_z        = slot[2];
        out_next.q_w        = slot[3];
        out_next.case_taken = last.sel;
        out_next.bad_input  = last.bad;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/rmq_checker.sv @@
// Checker: port-level properties of the matrix-to-quaternion pipeline, with its bind.
`timescale 1ns / 1ps

module rmq_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             matrix_valid,
    input logic             matrix_stall,
    input rmq_pkg::matrix_t matrix,
    input logic             quat_valid,
    input logic             quat_stall,
    input rmq_pkg::quat_t   quat
);
    import rmq_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid && $stable(quat))
        else $error("stalled result changed");

    // back-pressure reaches the input at once
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |-> matrix_stall)
        else $error("input not stalled while output stalled");

    // zero components on a bad root argument
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat.bad_input |->
            quat.q_x == 0 && quat.q_y == 0 && quat.q_z == 0 && quat.q_w == 0)
        else $error("bad input with nonzero components");

    // w root component is positive on a good transaction of the w case
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && !quat.bad_input && quat.case_taken == CASE_W |-> quat.q_w > 0)
        else $error("w root component not positive");

    // an offered transaction carries known fields
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid |-> !$isunknown(matrix))
        else $error("unknown matrix fields on a valid transaction");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .matrix_valid (matrix_valid),
    .matrix_stall (matrix_stall),
    .matrix       (matrix),
    .quat_valid   (quat_valid),
    .quat_stall   (quat_stall),
    .quat         (quat)
);
